// ===== hdl/eacd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the arc corner detector.
// No dependencies; every other file but eacd_ram uses this package.
package eacd_pkg;

  typedef struct packed {
    logic               kind;
    logic [6:0]         pixel_x;
    logic [6:0]         pixel_y;
    logic signed [31:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic is_corner;
    logic near_border;
  } out_item_t;

  typedef struct packed {
    logic [7:0] active_width;
    logic [7:0] active_height;
    logic [4:0] small_min_len;
    logic [4:0] small_max_len;
    logic [4:0] large_min_len;
    logic [4:0] large_max_len;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_BORDER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [6:0]         pixel_x;
    logic [6:0]         pixel_y;
    logic signed [31:0] stamp;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_RD,
    ST_EX,
    ST_DONE
  } back_state_t;

  localparam logic       KIND_WRITE = 1'b0;

  localparam logic [2:0] REG_ACTIVE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SMALL_MIN     = 3'd2;
  localparam logic [2:0] REG_SMALL_MAX     = 3'd3;
  localparam logic [2:0] REG_LARGE_MIN     = 3'd4;
  localparam logic [2:0] REG_LARGE_MAX     = 3'd5;

  localparam int         RING_DEPTH = 20;
  localparam logic [4:0] SMALL_N    = 5'd16;
  localparam logic [4:0] LARGE_N    = 5'd20;
  localparam logic [15:0] BORDER    = 16'd4;

  localparam logic signed [3:0] SMALL_DX [16] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1};
  localparam logic signed [3:0] SMALL_DY [16] = '{
    4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
    -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};
  localparam logic signed [3:0] LARGE_DX [20] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1};
  localparam logic signed [3:0] LARGE_DY [20] = '{
    4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4,
    -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4};

endpackage

// ===== hdl/eacd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module eacd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/eacd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and queues commands.
// Depends on eacd_pkg.
module eacd_front #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  eacd_pkg::in_item_t in_data,
  input  eacd_pkg::cfg_t   cfg,
  input  logic             clearing,
  output logic             q_valid,
  output eacd_pkg::cmd_t   q_cmd,
  input  logic             q_pop
);
  import eacd_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       accept, push, keep;
  logic [15:0] x16, y16, w16, h16;
  cmd_t       cmd;

  always_comb begin
    x16 = 16'(in_data.pixel_x);
    y16 = 16'(in_data.pixel_y);
    w16 = (16'(cfg.active_width) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : 16'(cfg.active_width);
    h16 = (16'(cfg.active_height) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT)
                                                     : 16'(cfg.active_height);
    cmd.pixel_x = in_data.pixel_x;
    cmd.pixel_y = in_data.pixel_y;
    cmd.stamp   = in_data.stamp;
    if (in_data.kind == KIND_WRITE) begin
      cmd.kind = CMD_WRITE;
      keep = (32'(in_data.pixel_x) < MAX_WIDTH) && (32'(in_data.pixel_y) < MAX_HEIGHT);
    end else begin
      keep = 1'b1;
      if (x16 < BORDER || x16 + BORDER >= w16 || y16 < BORDER || y16 + BORDER >= h16) begin
        cmd.kind = CMD_BORDER;
      end else begin
        cmd.kind = CMD_QUERY;
      end
    end
  end

  assign in_stall = clearing || (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign push     = accept && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/eacd_back.sv =====
`timescale 1ns / 1ps
// Back end: surface memory with clearing sweep, write execution and the
// sequential two-circle arc test. Depends on eacd_pkg and eacd_ram.
module eacd_back #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int STAMP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  eacd_pkg::cfg_t      cfg,
  output logic                clearing,
  input  logic                q_valid,
  input  eacd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output eacd_pkg::out_item_t out_data
);
  import eacd_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SB    = STAMP_BITS;
  localparam logic [SB-1:0] SIGN = {1'b1, {(SB-1){1'b0}}};

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        large_r, large_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [4:0]  iss_r, iss_nxt, rcv_r, rcv_nxt, top_r, top_nxt;
  logic [4:0]  lo_r, lo_nxt, hi_r, hi_nxt, it_r, it_nxt, size_r, size_nxt;
  logic        pend_r, pend_nxt, res_r, res_nxt;
  logic [SB-1:0] segmin_r, segmin_nxt, lmin_r, lmin_nxt, rmin_r, rmin_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [SB-1:0] s_wdata, s_rdata;
  logic          v_we;
  logic [SB-1:0] vlo, vhi;

  logic [4:0]  n, mn, mx, lmin_len, lmax_len, top_fin;
  logic signed [3:0] dx, dy;
  logic [7:0]  col, row;
  logic [SB-1:0] key, lmin_f, rmin_f;
  logic        out_free, pass, phase1, is_new_top;

  always_comb begin
    n        = large_r ? LARGE_N : SMALL_N;
    lmin_len = large_r ? cfg.large_min_len : cfg.small_min_len;
    lmax_len = large_r ? cfg.large_max_len : cfg.small_max_len;
    mn       = (lmin_len > n) ? n : lmin_len;
    mx       = (lmax_len > n) ? n : lmax_len;
    dx       = large_r ? LARGE_DX[iss_r] : SMALL_DX[iss_r[3:0]];
    dy       = large_r ? LARGE_DY[iss_r] : SMALL_DY[iss_r[3:0]];
    col      = {1'b0, cmd_r.pixel_x} + {{4{dx[3]}}, dx};
    row      = {1'b0, cmd_r.pixel_y} + {{4{dy[3]}}, dy};
    key      = SB'($signed(q_cmd.stamp)) ^ SIGN;
    lmin_f   = (vlo < lmin_r) ? vlo : lmin_r;
    rmin_f   = (vhi < rmin_r) ? vhi : rmin_r;
    phase1   = it_r < mn;
    pass     = (size_r <= mx) || (size_r >= n - mx && size_r <= n - mn);
    is_new_top = (rcv_r == 5'd0) || (s_rdata > segmin_r);
    top_fin  = is_new_top ? rcv_r : top_r;
    out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; large_nxt = large_r; clr_nxt = clr_r;
    iss_nxt = iss_r; rcv_nxt = rcv_r; top_nxt = top_r; lo_nxt = lo_r; hi_nxt = hi_r;
    it_nxt = it_r; size_nxt = size_r; pend_nxt = 1'b0; res_nxt = res_r;
    segmin_nxt = segmin_r; lmin_nxt = lmin_r; rmin_nxt = rmin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop   = 1'b0;
    s_we    = 1'b0;
    s_waddr = AW'(q_cmd.pixel_y) * AW'(MAX_WIDTH) + AW'(q_cmd.pixel_x);
    s_wdata = key;
    s_raddr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    v_we    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = SIGN;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_WRITE: begin
              q_pop = 1'b1;
              s_we  = 1'b1;
            end
            CMD_QUERY: begin
              q_pop     = 1'b1;
              cmd_nxt   = q_cmd;
              large_nxt = 1'b0;
              iss_nxt   = 5'd0;
              rcv_nxt   = 5'd0;
              state_nxt = ST_LOAD;
            end
            CMD_BORDER: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{is_corner: 1'b0, near_border: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        if (iss_r < n) begin
          pend_nxt = 1'b1;
          iss_nxt  = iss_r + 5'd1;
        end
        if (pend_r) begin
          v_we    = 1'b1;
          rcv_nxt = rcv_r + 5'd1;
          if (is_new_top) begin
            segmin_nxt = s_rdata;
            top_nxt    = rcv_r;
          end
          if (rcv_r == n - 5'd1) begin
            lo_nxt    = (top_fin == 5'd0) ? n - 5'd1 : top_fin - 5'd1;
            hi_nxt    = (top_fin == n - 5'd1) ? 5'd0 : top_fin + 5'd1;
            it_nxt    = 5'd1;
            size_nxt  = mn;
            lmin_nxt  = '1;
            rmin_nxt  = '1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_EX;
      end
      ST_EX: begin
        if (it_r == n) begin
          if (!large_r && pass) begin
            large_nxt = 1'b1;
            iss_nxt   = 5'd0;
            rcv_nxt   = 5'd0;
            state_nxt = ST_LOAD;
          end else begin
            res_nxt   = large_r && pass;
            state_nxt = ST_DONE;
          end
        end else begin
          lmin_nxt = lmin_f;
          rmin_nxt = rmin_f;
          it_nxt   = it_r + 5'd1;
          if (vhi > vlo) begin
            if (phase1 || vhi >= segmin_r) begin
              if (rmin_f < segmin_r) begin
                segmin_nxt = rmin_f;
              end
              if (!phase1) begin
                size_nxt = it_r + 5'd1;
              end
            end
            hi_nxt = (hi_r == n - 5'd1) ? 5'd0 : hi_r + 5'd1;
          end else begin
            if (phase1 || vlo >= segmin_r) begin
              if (lmin_f < segmin_r) begin
                segmin_nxt = lmin_f;
              end
              if (!phase1) begin
                size_nxt = it_r + 5'd1;
              end
            end
            lo_nxt = (lo_r == 5'd0) ? n - 5'd1 : lo_r - 5'd1;
          end
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{is_corner: res_r, near_border: 1'b0};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; large_r <= large_nxt; iss_r <= iss_nxt; rcv_r <= rcv_nxt;
    top_r <= top_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; it_r <= it_nxt;
    size_r <= size_nxt; res_r <= res_nxt; segmin_r <= segmin_nxt;
    lmin_r <= lmin_nxt; rmin_r <= rmin_nxt; out_data_r <= out_data_nxt;
  end

  eacd_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_surface (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  eacd_ram #(.WIDTH(SB), .DEPTH(RING_DEPTH)) u_ring_lo (
    .clk(clk), .we(v_we), .waddr(rcv_r), .wdata(s_rdata),
    .raddr(lo_r), .rdata(vlo)
  );

  eacd_ram #(.WIDTH(SB), .DEPTH(RING_DEPTH)) u_ring_hi (
    .clk(clk), .we(v_we), .waddr(rcv_r), .wdata(s_rdata),
    .raddr(hi_r), .rdata(vhi)
  );

  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/event_arc_corner_detector.sv =====
`timescale 1ns / 1ps
// Top level of the arc corner detector: config registers, front, back.
// Depends on eacd_pkg, eacd_front, eacd_back.
//
// After reset the surface is swept to zero, one pixel per cycle, over all
// MAX_WIDTH*MAX_HEIGHT pixels; no beats are taken meanwhile. A write beat
// is executed from the back end's idle state. A border query answers from
// the idle state once the output is free; a full query reads its circle
// pixels one per cycle from the single surface read port and then steps the
// arc expansion through the ring buffers in the ST_RD and ST_EX states; the
// large circle runs only when the small one passes. A two-entry command
// queue lets the input side take beats while the back end works, until full.
module event_arc_corner_detector #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int STAMP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  eacd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output eacd_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import eacd_pkg::*;

  cfg_t           cfg_r;
  logic           wr_en, clearing, q_valid, q_pop;
  cmd_t           q_cmd;
  logic [2:0]     reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{active_width: 8'd128, active_height: 8'd128, small_min_len: 5'd3,
                 small_max_len: 5'd6, large_min_len: 5'd4, large_max_len: 5'd8};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACTIVE_WIDTH:  cfg_r.active_width  <= cfg_pwdata[7:0];
        REG_ACTIVE_HEIGHT: cfg_r.active_height <= cfg_pwdata[7:0];
        REG_SMALL_MIN:     cfg_r.small_min_len <= cfg_pwdata[4:0];
        REG_SMALL_MAX:     cfg_r.small_max_len <= cfg_pwdata[4:0];
        REG_LARGE_MIN:     cfg_r.large_min_len <= cfg_pwdata[4:0];
        REG_LARGE_MAX:     cfg_r.large_max_len <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_WIDTH:  cfg_prdata = 32'(cfg_r.active_width);
      REG_ACTIVE_HEIGHT: cfg_prdata = 32'(cfg_r.active_height);
      REG_SMALL_MIN:     cfg_prdata = 32'(cfg_r.small_min_len);
      REG_SMALL_MAX:     cfg_prdata = 32'(cfg_r.small_max_len);
      REG_LARGE_MIN:     cfg_prdata = 32'(cfg_r.large_min_len);
      REG_LARGE_MAX:     cfg_prdata = 32'(cfg_r.large_max_len);
      default:           cfg_prdata = 32'd0;
    endcase
  end

  eacd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .cfg(cfg_r), .clearing(clearing),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  eacd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
              .STAMP_BITS(STAMP_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .clearing(clearing),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ===== hdl/eacd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the arc corner detector, bound to the top level.
// Depends on eacd_pkg and event_arc_corner_detector.
module eacd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input eacd_pkg::out_item_t out_data,
  input logic                cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_corner && out_data.near_border))
    else $error("corner reported on a border reject");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind event_arc_corner_detector eacd_checker u_eacd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data), .cfg_pready(cfg_pready)
);

// ===== bench/tb_event_arc_corner_detector.sv =====
`timescale 1ns / 1ps
// Testbench for event_arc_corner_detector: directed table, then random surface writes and
// corner queries under several register settings, checked against an in-bench predictor.
// Depends on eacd_pkg and the event_arc_corner_detector RTL.
module tb_event_arc_corner_detector;
  import eacd_pkg::*;

  localparam logic KIND_QUERY = ~KIND_WRITE;
  localparam int SURF_W = 128;
  localparam int SURF_H = 128;
  localparam int EDGE = 4;
  localparam int IDLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_CYCLES = 900;
  localparam out_item_t BORDER_HIT = '{is_corner: 1'b0, near_border: 1'b1};
  localparam out_item_t NO_HIT = '{is_corner: 1'b0, near_border: 1'b0};

  localparam int SRX[16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int SRY[16] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
  localparam int LRX[20] = '{0, 1, 2, 3, 4, 4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1};
  localparam int LRY[20] = '{4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1, 0, 1, 2, 3, 4};

  typedef struct {
    logic        kind;
    int          x;
    int          y;
    logic [31:0] st;
    bit          typed;
    out_item_t   res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [31:0] surface [SURF_W*SURF_H];
  int          act_w, act_h, sm_min, sm_max, lg_min, lg_max;
  out_item_t   answers_q[$];
  int          errors;
  int          send_idle, recv_idle;
  bit          hold_req, hold_done;
  int          hold_cnt;
  int          quiet_cycles;
  dir_row_t    dir_tab[];

  event_arc_corner_detector uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit arc_pass(int n, int minl, int maxl, int x, int y);
    logic [31:0] v[20];
    logic [31:0] segmin, lv, rv, lmin, rmin;
    int mn, mx, top, lo, hi, i, it, len, dx, dy;
    mn = (minl > n) ? n : minl;
    mx = (maxl > n) ? n : maxl;
    for (i = 0; i < n; i++) begin
      dx = (n == 16) ? SRX[i] : LRX[i];
      dy = (n == 16) ? SRY[i] : LRY[i];
      v[i] = surface[(y + dy) * SURF_W + x + dx] ^ 32'h8000_0000;
    end
    top = 0;
    segmin = v[0];
    for (i = 1; i < n; i++)
      if (v[i] > segmin) begin
        segmin = v[i];
        top = i;
      end
    lo = (top + n - 1) % n;
    hi = (top + 1) % n;
    lv = v[lo];
    rv = v[hi];
    lmin = lv;
    rmin = rv;
    for (it = 1; it < mn; it++) begin
      if (rv > lv) begin
        if (rmin < segmin) segmin = rmin;
        hi = (hi + 1) % n;
        rv = v[hi];
        if (rv < rmin) rmin = rv;
      end else begin
        if (lmin < segmin) segmin = lmin;
        lo = (lo + n - 1) % n;
        lv = v[lo];
        if (lv < lmin) lmin = lv;
      end
    end
    len = mn;
    for (; it < n; it++) begin
      if (rv > lv) begin
        if (rv >= segmin) begin
          len = it + 1;
          if (rmin < segmin) segmin = rmin;
        end
        hi = (hi + 1) % n;
        rv = v[hi];
        if (rv < rmin) rmin = rv;
      end else begin
        if (lv >= segmin) begin
          len = it + 1;
          if (lmin < segmin) segmin = lmin;
        end
        lo = (lo + n - 1) % n;
        lv = v[lo];
        if (lv < lmin) lmin = lv;
      end
    end
    return (len <= mx) || (len >= n - mx && len <= n - mn);
  endfunction

  // Updates the surface on a write beat; returns 1 and the answer on a query beat.
  function automatic bit corner_answer(in_item_t it, output out_item_t res);
    int x, y, w, h;
    x = it.pixel_x;
    y = it.pixel_y;
    res = NO_HIT;
    if (it.kind == KIND_WRITE) begin
      surface[y * SURF_W + x] = it.stamp;
      return 1'b0;
    end
    w = (act_w > SURF_W) ? SURF_W : act_w;
    h = (act_h > SURF_H) ? SURF_H : act_h;
    if (x < EDGE || x >= w - EDGE || y < EDGE || y >= h - EDGE) begin
      res = BORDER_HIT;
    end else begin
      res.is_corner = arc_pass(16, sm_min, sm_max, x, y) && arc_pass(20, lg_min, lg_max, x, y);
    end
    return 1'b1;
  endfunction

  task automatic send_beat(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (corner_answer(it, res)) answers_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_ACTIVE_WIDTH:  act_w = val & 8'hFF;
      REG_ACTIVE_HEIGHT: act_h = val & 8'hFF;
      REG_SMALL_MIN:     sm_min = val & 5'h1F;
      REG_SMALL_MAX:     sm_max = val & 5'h1F;
      REG_LARGE_MIN:     lg_min = val & 5'h1F;
      REG_LARGE_MAX:     lg_max = val & 5'h1F;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(int aw, int ah, int smn, int smx, int lmn, int lmx);
    reg_write(REG_ACTIVE_WIDTH, aw);
    reg_write(REG_ACTIVE_HEIGHT, ah);
    reg_write(REG_SMALL_MIN, smn);
    reg_write(REG_SMALL_MAX, smx);
    reg_write(REG_LARGE_MIN, lmn);
    reg_write(REG_LARGE_MAX, lmx);
  endtask

  // Mostly bursts of stamps around one pixel followed by a query there; the rest is noise.
  task automatic random_traffic(int count);
    in_item_t it;
    int sent, k, j, w, h, cx, cy;
    logic [31:0] base;
    sent = 0;
    while (sent < count) begin
      it.stamp = $urandom;
      if ($urandom_range(99) < 75) begin
        w = (act_w > SURF_W) ? SURF_W : act_w;
        h = (act_h > SURF_H) ? SURF_H : act_h;
        cx = (w >= 9) ? $urandom_range(EDGE, w - 5) : $urandom_range(SURF_W - 1);
        cy = (h >= 9) ? $urandom_range(EDGE, h - 5) : $urandom_range(SURF_H - 1);
        base = $urandom;
        k = $urandom_range(1, 10);
        for (j = 0; j < k; j++) begin
          it.kind = KIND_WRITE;
          it.pixel_x = cx + $urandom_range(8) - 4;
          it.pixel_y = cy + $urandom_range(8) - 4;
          it.stamp = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(40);
          send_beat(it, 1'b0, NO_HIT);
        end
        it.kind = KIND_QUERY;
        it.pixel_x = cx;
        it.pixel_y = cy;
        send_beat(it, 1'b0, NO_HIT);
        sent += k + 1;
      end else begin
        it.kind = $urandom_range(1);
        it.pixel_x = $urandom_range(127);
        it.pixel_y = $urandom_range(127);
        send_beat(it, 1'b0, NO_HIT);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, out_data);
        errors++;
      end else begin
        if (out_data.is_corner !== answers_q[0].is_corner)
          $display("%0t: is_corner mismatch, expected %b, actual %b", $time,
                   answers_q[0].is_corner, out_data.is_corner);
        if (out_data.near_border !== answers_q[0].near_border)
          $display("%0t: near_border mismatch, expected %b, actual %b", $time,
                   answers_q[0].near_border, out_data.near_border);
        if (out_data !== answers_q[0]) errors++;
        void'(answers_q.pop_front());
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    foreach (surface[n]) surface[n] = '0;
    act_w = 128;
    act_h = 128;
    sm_min = 3;
    sm_max = 6;
    lg_min = 4;
    lg_max = 8;
    dir_tab = '{
      '{KIND_QUERY, 4, 4, 32'd0, 1'b0, NO_HIT},
      '{KIND_QUERY, 0, 0, 32'd0, 1'b1, BORDER_HIT},
      '{KIND_QUERY, 127, 127, 32'd0, 1'b1, BORDER_HIT},
      '{KIND_QUERY, 3, 64, 32'd0, 1'b1, BORDER_HIT},
      '{KIND_QUERY, 124, 64, 32'd0, 1'b1, BORDER_HIT},
      '{KIND_QUERY, 64, 124, 32'd0, 1'b1, BORDER_HIT},
      '{KIND_QUERY, 123, 123, 32'd0, 1'b0, NO_HIT},
      '{KIND_WRITE, 127, 127, 32'h7FFF_FFFF, 1'b0, NO_HIT},
      '{KIND_WRITE, 0, 0, 32'h8000_0000, 1'b0, NO_HIT},
      '{KIND_WRITE, 127, 0, 32'd0, 1'b0, NO_HIT},
      '{KIND_WRITE, 20, 23, 32'd1000, 1'b0, NO_HIT},
      '{KIND_WRITE, 21, 23, 32'd1000, 1'b0, NO_HIT},
      '{KIND_WRITE, 19, 23, 32'd1000, 1'b0, NO_HIT},
      '{KIND_WRITE, 20, 24, 32'd1000, 1'b0, NO_HIT},
      '{KIND_WRITE, 21, 24, 32'd1000, 1'b0, NO_HIT},
      '{KIND_WRITE, 19, 24, 32'd1000, 1'b0, NO_HIT},
      '{KIND_QUERY, 20, 20, 32'd0, 1'b0, NO_HIT},
      '{KIND_WRITE, 23, 20, 32'hFFFF_FFFB, 1'b0, NO_HIT},
      '{KIND_WRITE, 17, 20, 32'h7FFF_FFFF, 1'b0, NO_HIT},
      '{KIND_QUERY, 20, 20, 32'd0, 1'b0, NO_HIT},
      '{KIND_QUERY, 123, 123, 32'd0, 1'b0, NO_HIT}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[r]) begin
      it.kind = dir_tab[r].kind;
      it.pixel_x = dir_tab[r].x;
      it.pixel_y = dir_tab[r].y;
      it.stamp = dir_tab[r].st;
      send_beat(it, dir_tab[r].typed, dir_tab[r].res);
    end
    drain();
    apply_cfg(128, 128, 3, 6, 4, 8);
    send_idle = 20;
    recv_idle = 48;
    random_traffic(450);
    drain();
    apply_cfg(255, 60, 0, 16, 1, 20);
    send_idle = 48;
    recv_idle = 20;
    random_traffic(450);
    drain();
    apply_cfg(100, 128, 31, 31, 0, 0);
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    random_traffic(450);
    drain();
    apply_cfg(9, 9, 1, 5, 20, 31);
    for (i = 0; i < 4; i++) random_traffic(100);
    drain();
    if (errors == 0 && answers_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/eacd_pkg.sv
hdl/eacd_ram.sv
hdl/eacd_front.sv
hdl/eacd_back.sv
hdl/event_arc_corner_detector.sv
hdl/eacd_checker.sv
bench/tb_event_arc_corner_detector.sv
